// ===== rtl/core/adv_pkg.sv =====
// ----------------------------------------------------------------------------
// adv_pkg: shared types and constants of the advertiser/scanner tick model
// Holds the request and response payloads and the per-beacon memory record.
// ----------------------------------------------------------------------------
package adv_pkg;

   localparam int MaxBeacons = 8;
   localparam int IdxW       = $clog2(MaxBeacons);
   localparam int CntW       = $clog2(MaxBeacons + 1);
   localparam logic [23:0] MaxDelay = 24'hFFFFFF;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [2:0] CSR_WINDOW   = 3'd0;
   localparam logic [2:0] CSR_INTERVAL = 3'd1;
   localparam logic [2:0] CSR_SEND     = 3'd2;
   localparam logic [2:0] CSR_PKTLEN   = 3'd3;
   localparam logic [2:0] CSR_GAP      = 3'd4;
   localparam logic [2:0] CSR_USED     = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  beacon_index;
      logic [23:0] start_delay;
      logic [30:0] random_word;
   } req_type;

   typedef struct packed {
      logic [3:0]  identified_count;
      logic        all_identified;
      logic [31:0] hit_count;
      logic [31:0] sent_count;
      logic [31:0] tick_count;
   } rsp_type;

   typedef struct packed {
      logic [23:0] countdown;
      logic [11:0] remaining;
      logic        active;
      logic        failed;
      logic        identified;
      logic [1:0]  channel;
   } beacon_type;

   // Millisecond count r / 1000, taken as (r / 8) / 125 by a reciprocal
   // multiplication that is exact for every 28-bit quotient r / 8.
   function automatic logic [21:0] rand_ms(input logic [30:0] rnd);
      logic [56:0] prod;
      prod = 57'(rnd[30:3]) * 57'd274877907;
      return prod[56:35];
   endfunction

   // (ms mod 11) * 1000; the quotient by 11 comes from a reciprocal
   // multiplication that is exact for every 22-bit millisecond count.
   function automatic logic [13:0] rand_delay(input logic [21:0] ms);
      logic [44:0] prod;
      logic [21:0] q;
      logic [3:0]  rem;
      prod = 45'(ms) * 45'd6100806;
      q    = 22'(prod[44:26]);
      rem  = 4'(ms - q * 22'd11);
      return 14'(rem) * 14'd1000;
   endfunction

endpackage

// ===== rtl/core/adv_ram.sv =====
// ----------------------------------------------------------------------------
// adv_ram: beacon state memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module adv_ram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [adv_pkg::IdxW-1:0] wr_addr,
   input  adv_pkg::beacon_type    wr_data,
   input  logic [adv_pkg::IdxW-1:0] rd_addr,
   output adv_pkg::beacon_type    rd_data
);
   import adv_pkg::*;

   beacon_type mem_ff [MaxBeacons];
   beacon_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== rtl/core/advertiser_scanner_tick_sim.sv =====
// ----------------------------------------------------------------------------
// advertiser_scanner_tick_sim: BLE-style advertiser and scanner tick model
// Beacon state lives in a small memory walked once per pass by a sequencer.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | adv_pkg::req_type
//   rsp_    | out       | rsp_valid/rsp_stall | adv_pkg::rsp_type
//   csr_    | in        | csr_write          | csr_index, csr_data
//
// A load steps through the states LOADR, LOADW and DONE. A tick takes two passes over
// the beacon memory, P1 and P2 with MID between them, then DONE; each pass walks the
// n beacons in use through the single read port of the beacon memory.
// After reset a clearing pass writes the reset record to every entry; no
// request is taken meanwhile. The response sits in an output register; a
// stalled response holds the next request in its final state.
// ----------------------------------------------------------------------------
module advertiser_scanner_tick_sim (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  adv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output adv_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_data
);
   import adv_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_P1    = 8'b0000_0100,
      ST_MID   = 8'b0000_1000,
      ST_P2    = 8'b0001_0000,
      ST_LOADR = 8'b0010_0000,
      ST_LOADW = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [23:0] window_ff, interval_ff, send_ff;
   logic [11:0] pktlen_ff;
   logic [15:0] gap_ff;
   logic [3:0]  used_ff;
   req_type     req_ff;
   // The random delay is built in ms_ff and then dly_ff before the first beacon write.
   logic [21:0] ms_ff;
   logic [13:0] dly_ff;
   // Address counter: issues reads, counts one beyond for the trailing write.
   logic [IdxW:0] cnt_ff, cnt_in;
   logic          rdv_ff;            // read data valid for address rda_ff
   logic [IdxW-1:0] rda_ff;
   logic [23:0] elapsed_ff;
   logic [1:0]  scan_ff;
   logic [3:0]  ident_ff;
   logic [31:0] hits_ff, sent_ff, ticks_ff;
   logic [CntW-1:0] onscan_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic        wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   beacon_type  wr_data, rd_data, upd;
   logic [CntW-1:0] n_used;
   logic        hit, new_ident, is_onscan;
   logic signed [26:0] nxt;

   adv_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign n_used  = (used_ff > 4'(MaxBeacons)) ? CntW'(MaxBeacons) : CntW'(used_ff);
   assign rd_addr = cnt_ff[IdxW-1:0];
   assign nxt     = 27'(send_ff) + 27'(dly_ff) - 27'(3 * 14'(pktlen_ff))
                    - 27'({gap_ff, 1'b0});

   // Pass-one beacon update.
   always_comb begin
      upd       = rd_data;
      hit       = 1'b0;
      new_ident = 1'b0;
      if (rd_data.countdown != 24'd0) begin
         upd.countdown = rd_data.countdown - 24'd1;
         upd.active    = 1'b0;
      end else if (rd_data.remaining != 12'd0) begin
         upd.active    = 1'b1;
         upd.remaining = rd_data.remaining - 12'd1;
         if (elapsed_ff > window_ff || rd_data.channel != scan_ff) upd.failed = 1'b1;
      end else begin
         hit = !rd_data.failed && elapsed_ff < window_ff && rd_data.channel == scan_ff;
         new_ident = hit && !rd_data.identified;
         if (hit) upd.identified = 1'b1;
         upd.active    = 1'b0;
         upd.remaining = pktlen_ff;
         upd.failed    = 1'b0;
         if (rd_data.channel >= 2'd2) begin
            upd.channel = 2'd0;
            if (nxt < 0) upd.countdown = 24'd0;
            else if (nxt > 27'(MaxDelay)) upd.countdown = MaxDelay;
            else upd.countdown = nxt[23:0];
         end else begin
            upd.channel   = rd_data.channel + 2'd1;
            upd.countdown = 24'(gap_ff);
         end
      end
      is_onscan = upd.active && upd.channel == scan_ff;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rda_ff;
      wr_data = upd;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IdxW-1:0];
            wr_data = '{countdown: 24'd0, remaining: 12'd368, active: 1'b0,
                        failed: 1'b0, identified: 1'b0, channel: 2'd0};
         end
         ST_P1: wr_en = rdv_ff;
         ST_P2: begin
            wr_en   = rdv_ff && onscan_ff > CntW'(1) && rd_data.active
                      && rd_data.channel == scan_ff;
            wr_data = rd_data;
            wr_data.failed = 1'b1;
         end
         ST_LOADW: begin
            wr_en   = 1'b1;
            wr_data = '{countdown: req_ff.start_delay, remaining: pktlen_ff,
                        active: 1'b0, failed: 1'b0, identified: 1'b0, channel: 2'd0};
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IdxW+1)'(MaxBeacons - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cnt_in = (IdxW+1)'(0);
            if (req_valid) begin
               if (req_data.opcode == OP_LOAD) begin
                  state_in = ST_LOADR;
                  cnt_in   = (IdxW+1)'(req_data.beacon_index);
               end else begin
                  state_in = ST_P1;
               end
            end
         end
         ST_P1, ST_P2: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff >= (IdxW+1)'(n_used)) begin
               state_in = (state_ff == ST_P1) ? ST_MID : ST_DONE;
               cnt_in   = (IdxW+1)'(0);
            end
         end
         ST_MID:   state_in = ST_P2;
         ST_LOADR: state_in = ST_LOADW;
         ST_LOADW: state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rdv_ff       <= 1'b0;
         rda_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= 24'd10000;
         interval_ff  <= 24'd1000000;
         send_ff      <= 24'd500000;
         pktlen_ff    <= 12'd368;
         gap_ff       <= 16'd100;
         used_ff      <= 4'd1;
         elapsed_ff   <= '0;
         scan_ff      <= '0;
         ident_ff     <= '0;
         hits_ff      <= '0;
         sent_ff      <= '0;
         ticks_ff     <= '0;
         onscan_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rda_ff   <= cnt_ff[IdxW-1:0];
         rdv_ff   <= (state_ff == ST_P1 || state_ff == ST_P2)
                     && cnt_ff < (IdxW+1)'(n_used);
         if (csr_write) begin
            case (csr_index)
               CSR_WINDOW:   window_ff   <= csr_data;
               CSR_INTERVAL: interval_ff <= csr_data;
               CSR_SEND:     send_ff     <= csr_data;
               CSR_PKTLEN:   pktlen_ff   <= csr_data[11:0];
               CSR_GAP:      gap_ff      <= csr_data[15:0];
               CSR_USED:     used_ff     <= csr_data[3:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE) onscan_ff <= '0;
         if (state_ff == ST_P1 && rdv_ff) begin
            if (is_onscan && onscan_ff != CntW'(MaxBeacons)) onscan_ff <= onscan_ff + 1'b1;
            if (rd_data.countdown == 24'd0 && rd_data.remaining == 12'd0) begin
               sent_ff <= sent_ff + 32'd1;
               if (hit) hits_ff <= hits_ff + 32'd1;
               if (new_ident) ident_ff <= ident_ff + 4'd1;
            end
         end
         if (state_ff == ST_MID) begin
            ticks_ff <= ticks_ff + 32'd1;
            if (elapsed_ff + 24'd1 >= interval_ff) begin
               elapsed_ff <= '0;
               scan_ff    <= (scan_ff >= 2'd2) ? 2'd0 : scan_ff + 2'd1;
            end else begin
               elapsed_ff <= elapsed_ff + 24'd1;
            end
         end
         if (state_ff == ST_LOADW && rd_data.identified && ident_ff != 4'd0)
            ident_ff <= ident_ff - 4'd1;
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_data;
         ms_ff  <= rand_ms(req_data.random_word);
      end
      dly_ff <= rand_delay(ms_ff);
      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.identified_count <= ident_ff;
         rsp_ff.all_identified   <= CntW'(ident_ff) >= n_used;
         rsp_ff.hit_count        <= hits_ff;
         rsp_ff.sent_count       <= sent_ff;
         rsp_ff.tick_count       <= ticks_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("request taken while busy");
   a_ident_bound: assert property (@(posedge clock) disable iff (reset)
      ident_ff <= 4'(MaxBeacons))
      else $error("identified count exceeds beacon count");
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MID |=> ticks_ff == $past(ticks_ff) + 32'd1)
      else $error("tick count did not advance");
`endif
endmodule
